// File: rtl/wbps_pkg.sv
// Shared constants and types for the wildcard byte pattern scanner.
package wbps_pkg;

	// Window and pattern sizing
	localparam int PATTERN_MAX   = 32;
	localparam int PATTERN_STORE = 32;
	localparam int LEN_CAP       = (PATTERN_MAX < PATTERN_STORE) ? PATTERN_MAX : PATTERN_STORE;
	localparam int LEN_W         = 6;
	localparam int PIDX_W        = 5;
	localparam int CNT_W         = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_MASK  = 3'd5;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] offset;
	} result_t;

endpackage

// File: rtl/wbps_cell.sv
// One window cell: holds one image byte and compares the byte shifting in.
module wbps_cell
	import wbps_pkg::*;
(
	input  logic  clk,
	input  logic  shift,
	input  byte_t byte_in,
	input  byte_t pat_byte,
	input  logic  care,
	output byte_t byte_q,
	output logic  hit
);

	// Window storage, advances one place per accepted byte
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	// Position matches when ignored or equal
	assign hit = !care || (byte_in == pat_byte);

endmodule

// File: rtl/wbps_chain.sv
// Row of window cells with pattern alignment and match reduction.
module wbps_chain
	import wbps_pkg::*;
(
	input  logic                       clk,
	input  logic                       shift,
	input  byte_t                      data_byte,
	input  logic [PATTERN_STORE*8-1:0] pattern_flat,
	input  logic [PATTERN_STORE-1:0]   wild_mask,
	input  logic [LEN_W-1:0]           len_eff,
	output logic                       match
);

	byte_t              taps [LEN_CAP];
	logic [LEN_CAP-1:0] hits;

	genvar j;
	generate
		for (j = 0; j < LEN_CAP; j++) begin : g_cell
			logic              in_use;
			logic [LEN_W-1:0]  pidx_full;
			logic [PIDX_W-1:0] pidx;
			byte_t             pat_sel;
			byte_t             byte_in;
			logic              care;

			// Cell j compares window byte j (newest is 0) with pattern byte len-1-j
			assign in_use    = LEN_W'(j) < len_eff;
			assign pidx_full = len_eff - LEN_W'(j) - LEN_W'(1);
			assign pidx      = pidx_full[PIDX_W-1:0];
			assign pat_sel   = pattern_flat[pidx*8 +: 8];
			assign care      = in_use && !wild_mask[pidx];

			if (j == 0) begin : g_head
				assign byte_in = data_byte;
			end else begin : g_body
				assign byte_in = taps[j-1];
			end

			// The last cell's stored byte leaves the window and is not read
			wbps_cell u_cell (
				.clk      (clk),
				.shift    (shift),
				.byte_in  (byte_in),
				.pat_byte (pat_sel),
				.care     (care),
				.byte_q   (taps[j]),
				.hit      (hits[j])
			);
		end
	endgenerate

	// Whole window matches
	assign match = &hits;

endmodule

// File: rtl/wildcard_byte_pattern_scan_top.sv
// Top level of the wildcard byte pattern scanner.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = last
//  m_*       out  m_tvalid/m_tready  m_tdata = match_offset, m_tuser = found
//  cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// One byte per cycle while s_tready is high: the window shifts and all cells compare
// in the cycle the byte is accepted; its result is registered into the output register.
// A result that meets a stalled output waits in a holding register; s_tready drops only
// while that register is full, so the input stalls only with two results waiting.
// arst_n clears the counter, match flag, both result valids, pattern words and mask and
// sets length to one. Window bytes are not cleared; the byte count bars stale matches.
module wildcard_byte_pattern_scan_top
	import wbps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] data_byte
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // [31:0] match_offset
	output logic                  m_tuser,   // [0] found
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [LEN_W-1:0]                pattern_length_q;
	logic [3:0][63:0]                pattern_words_q;
	logic [PATTERN_STORE-1:0]        wildcard_mask_q;
	logic [LEN_W-1:0]                len_eff;
	logic [CNT_W-1:0]                bytes_seen_q;
	logic [CNT_W-1:0]                count_next;
	logic                            reported_q;
	logic                            accept;
	logic                            match;
	logic                            found;
	logic                            emit;
	logic                            push;
	result_t                         res_new;
	result_t                         res_s1;
	result_t                         skid_q;
	logic                            out_valid_q;
	logic                            skid_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LEN_W'(1);
			pattern_words_q  <= '0;
			wildcard_mask_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN_LENGTH: pattern_length_q   <= cfg_data[LEN_W-1:0];
				CFG_PATTERN_WORD_0: pattern_words_q[0] <= cfg_data;
				CFG_PATTERN_WORD_1: pattern_words_q[1] <= cfg_data;
				CFG_PATTERN_WORD_2: pattern_words_q[2] <= cfg_data;
				CFG_PATTERN_WORD_3: pattern_words_q[3] <= cfg_data;
				CFG_WILDCARD_MASK:  wildcard_mask_q    <= cfg_data[PATTERN_STORE-1:0];
				default: ;
			endcase
		end
	end

	// Effective length: zero means one, saturate at window size
	always_comb begin
		len_eff = pattern_length_q;
		if (len_eff == '0) begin
			len_eff = LEN_W'(1);
		end
		if (len_eff > LEN_W'(LEN_CAP)) begin
			len_eff = LEN_W'(LEN_CAP);
		end
	end

	assign accept = s_tvalid && s_tready;

	wbps_chain u_chain (
		.clk          (clk),
		.shift        (accept),
		.data_byte    (s_tdata),
		.pattern_flat (pattern_words_q),
		.wild_mask    (wildcard_mask_q),
		.len_eff      (len_eff),
		.match        (match)
	);

	// Result decision for the byte being accepted
	assign count_next = bytes_seen_q + CNT_W'(1);
	assign found      = !reported_q && (count_next >= CNT_W'(len_eff)) && match;
	assign emit       = found || (s_tlast && !reported_q);
	assign push       = accept && emit;

	always_comb begin
		res_new.found  = found;
		res_new.offset = found ? (count_next - CNT_W'(len_eff)) : '0;
	end

	// Per-image state: byte count and first-match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			reported_q   <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				bytes_seen_q <= '0;
				reported_q   <= 1'b0;
			end else begin
				bytes_seen_q <= count_next;
				reported_q   <= reported_q || found;
			end
		end
	end

	// Output register with a holding register behind it
	assign s_tready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				res_s1 <= skid_q;
			end else if (push) begin
				res_s1 <= res_new;
			end
		end else if (push) begin
			skid_q <= res_new;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_s1.offset;
	assign m_tuser  = res_s1.found;

	// A result never follows an already reported match
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |-> !reported_q)
		else $error("result issued after match already reported");

	// Last byte always leaves a clean image state
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> bytes_seen_q == '0 && !reported_q)
		else $error("image state not cleared after last byte");

	// Not-found transactions carry a zero offset
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("not-found result with nonzero offset");

	// A found result marks the image as reported unless it ended it
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && found && !s_tlast |=> reported_q)
		else $error("match flag not set after found result");

	// The holding register is only used behind a full output register
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("holding register full while output register empty");

endmodule
